>>> hw/rtl/cbor_pkg.sv
// Package for the CBOR stream decoder: payload structs, phase enum, codes, half widening.
// No dependencies.
package cbor_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_req_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [63:0] token_value;
        logic [1:0]  float_format;
        logic [4:0]  nest_depth;
        logic        is_map_key;
        logic        message_done;
        logic [3:0]  status;
    } out_req_t;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_ARG,
        PH_PAYLOAD,
        PH_DONE,
        PH_DRAIN,
        PH_POP,
        PH_OUT
    } phase_t;

    localparam logic [3:0] TK_UINT    = 4'd0;
    localparam logic [3:0] TK_NEGINT  = 4'd1;
    localparam logic [3:0] TK_FALSE   = 4'd6;
    localparam logic [3:0] TK_FLOAT   = 4'd9;
    localparam logic [3:0] TK_PAYLOAD = 4'd10;
    localparam logic [3:0] TK_STATUS  = 4'd11;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_TRUNC     = 4'd1;
    localparam logic [3:0] ST_BAD_INFO  = 4'd2;
    localparam logic [3:0] ST_UINT_BIG  = 4'd3;
    localparam logic [3:0] ST_NEG_BIG   = 4'd4;
    localparam logic [3:0] ST_KEY_TEXT  = 4'd5;
    localparam logic [3:0] ST_SIMPLE    = 4'd6;
    localparam logic [3:0] ST_MAJOR     = 4'd7;
    localparam logic [3:0] ST_TRAILING  = 4'd8;
    localparam logic [3:0] ST_TOO_DEEP  = 4'd9;

    localparam logic [1:0] FF_NONE = 2'd0;
    localparam logic [1:0] FF_HALF = 2'd1;
    localparam logic [1:0] FF_SGL  = 2'd2;
    localparam logic [1:0] FF_DBL  = 2'd3;

    localparam logic [63:0] INT64_TOP = 64'h7fff_ffff_ffff_ffff;

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [7:0]  e;
        logic [10:0] m;
        logic [31:0] r;
        ex  = h[14:10];
        man = h[9:0];
        r   = {h[15], 31'd0};
        if (ex == 5'd0) begin
            if (man != 10'd0) begin
                m = {1'b0, man};
                e = 8'd113;
                for (int i = 0; i < 10; i++) begin
                    if (m[10] == 1'b0) begin
                        m = {m[9:0], 1'b0};
                        e = e - 8'd1;
                    end
                end
                r = {h[15], e, m[9:0], 13'd0};
            end
        end else if (ex == 5'h1f) begin
            r = {h[15], 8'hff, man, 13'd0};
        end else begin
            r = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/cbor_stack_mem.sv
// Nesting stack memory: remaining count, map flag and expect-key flag per level.
// Depends on nothing; one write port, one registered read port.
module cbor_stack_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [65:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [65:0]   rd_data
);

    logic [65:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/cbor_stream_decoder_top.sv
// CBOR stream decoder top level: byte sequencer around the nesting stack memory.
// Depends on cbor_pkg and cbor_stack_mem.
//
// channel  | direction | payload
// in_*     | in        | cbor_pkg::in_req_t  (data_byte, end_of_message)
// out_*    | out       | cbor_pkg::out_req_t (token fields, status)
//
// A request is taken while the top stack entry is read, and is then decided on.
// A request that gives a result also holds off intake in the cycle in which the result is taken.
// Each finished container popped costs a further memory read.
// A result waits in the output register; the next request is not taken until it leaves.
// rst_n clears all control state; stack entries are written before they are read.
module cbor_stream_decoder_top #(
    parameter int MAX_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cbor_pkg::in_req_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cbor_pkg::out_req_t out_data
);

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int LW = $clog2(MAX_DEPTH + 1);

    cbor_pkg::phase_t   phase_reg, phase_next;
    logic               busy_reg, busy_next;
    logic [7:0]         byte_reg, byte_next;
    logic               eom_reg, eom_next;
    logic [63:0]        acc_reg, acc_next;
    logic [3:0]         left_reg, left_next;
    logic [2:0]         major_reg, major_next;
    logic [4:0]         info_reg, info_next;
    logic [63:0]        pay_reg, pay_next;
    logic [LW-1:0]      lvl_reg, lvl_next;
    logic               ov_reg, ov_next;
    cbor_pkg::out_req_t od_reg, od_next;
    cbor_pkg::out_req_t tk_reg, tk_next;
    logic               wasdr_reg, wasdr_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [65:0]        wr_data, rd_data;

    cbor_stack_mem #(.DEPTH(MAX_DEPTH), .AW(AW)) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [63:0] t_rem;
    logic        t_map, t_key;
    assign t_rem = rd_data[65:2];
    assign t_map = rd_data[1];
    assign t_key = rd_data[0];

    logic [LW-1:0] lvl_m1;
    assign lvl_m1  = lvl_reg - LW'(1);
    // top entry of the level the next cycle works on
    assign rd_addr = AW'(lvl_next - LW'(1));

    assign in_ready  = !busy_reg && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cbor_pkg::PH_HEAD;
            busy_reg  <= 1'b0;
            acc_reg   <= '0;
            left_reg  <= '0;
            major_reg <= '0;
            info_reg  <= '0;
            pay_reg   <= '0;
            lvl_reg   <= '0;
            ov_reg    <= 1'b0;
            wasdr_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            major_reg <= major_next;
            info_reg  <= info_next;
            pay_reg   <= pay_next;
            lvl_reg   <= lvl_next;
            ov_reg    <= ov_next;
            wasdr_reg <= wasdr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        eom_reg  <= eom_next;
        od_reg   <= od_next;
        tk_reg   <= tk_next;
    end

    // Sequencer. busy_reg=1 with phase PH_HEAD/ARG/PAYLOAD/DONE/DRAIN: decide cycle
    // (stack top read data valid). PH_POP: finish_item loop, one level per cycle.
    always_comb
    begin
        logic [2:0]  mj;
        logic [4:0]  inf;
        logic        simple_ok, inkey, have, fin;
        logic [3:0]  st;
        logic [63:0] arg;
        cbor_pkg::out_req_t tk;
        logic [63:0] nrem;

        phase_next = phase_reg;
        busy_next  = busy_reg;
        byte_next  = byte_reg;
        eom_next   = eom_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        major_next = major_reg;
        info_next  = info_reg;
        pay_next   = pay_reg;
        lvl_next   = lvl_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        tk_next    = tk_reg;
        wasdr_next = wasdr_reg;
        wr_en      = 1'b0;
        wr_addr    = AW'(lvl_m1);
        wr_data    = rd_data;
        mj = byte_reg[7:5];
        inf = byte_reg[4:0];
        simple_ok = (inf >= 5'd20 && inf <= 5'd22) || (inf >= 5'd25 && inf <= 5'd27);
        inkey = (lvl_reg != '0) && t_map && t_key;
        have = 1'b0;
        fin = 1'b0;
        st = cbor_pkg::ST_OK;
        arg = '0;
        nrem = t_rem - 64'd1;
        tk = tk_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        if (!busy_reg)
        begin
            if (in_valid && in_ready)
            begin
                byte_next  = in_data.data_byte;
                eom_next   = in_data.end_of_message;
                busy_next  = 1'b1;
                wasdr_next = (phase_reg == cbor_pkg::PH_DRAIN);
                tk_next    = '0;
                tk_next.token_kind = cbor_pkg::TK_STATUS;
                tk_next.nest_depth = 5'(lvl_reg);
            end
        end
        else if (phase_reg == cbor_pkg::PH_POP)
        begin
            // finish_item loop body on top entry (rd_data is entry lvl-1)
            if (lvl_reg == '0)
            begin
                have = 1'b1;
                phase_next = cbor_pkg::PH_DONE;
            end
            else if (t_map && t_key)
            begin
                wr_en = 1'b1;
                wr_data = {t_rem, t_map, 1'b0};
                have = 1'b1;
                phase_next = cbor_pkg::PH_HEAD;
            end
            else
            begin
                wr_en = 1'b1;
                wr_data = {nrem, t_map, t_map};
                if (nrem != 64'd0)
                begin
                    have = 1'b1;
                    phase_next = cbor_pkg::PH_HEAD;
                end
                else
                begin
                    lvl_next = lvl_m1;
                end
            end
            st = cbor_pkg::ST_OK;
        end
        else
        begin
            case (phase_reg)
                cbor_pkg::PH_DONE:
                begin
                    st = cbor_pkg::ST_TRAILING;
                    have = 1'b1;
                end
                cbor_pkg::PH_DRAIN:
                begin
                    have = 1'b0;
                end
                cbor_pkg::PH_PAYLOAD:
                begin
                    tk.token_kind = cbor_pkg::TK_PAYLOAD;
                    tk.token_value = {56'd0, byte_reg};
                    have = 1'b1;
                    pay_next = pay_reg - 64'd1;
                    if (pay_reg == 64'd1)
                    begin
                        fin = 1'b1;
                    end
                end
                cbor_pkg::PH_ARG:
                begin
                    acc_next = {acc_reg[55:0], byte_reg};
                    if (left_reg <= 4'd1)
                    begin
                        left_next = '0;
                        arg = acc_next;
                        have = 1'b1;
                    end
                    else
                    begin
                        left_next = left_reg - 4'd1;
                    end
                end
                cbor_pkg::PH_HEAD:
                begin
                    if (mj == 3'd6)
                    begin
                        st = cbor_pkg::ST_MAJOR;
                    end
                    else if (mj == 3'd7 && !simple_ok)
                    begin
                        st = cbor_pkg::ST_SIMPLE;
                    end
                    else if (mj != 3'd7 && inf > 5'd27)
                    begin
                        st = cbor_pkg::ST_BAD_INFO;
                    end
                    else if (inkey && mj != 3'd3)
                    begin
                        st = cbor_pkg::ST_KEY_TEXT;
                    end
                    else
                    begin
                        major_next = mj;
                        info_next = inf;
                        if (mj == 3'd7 && inf <= 5'd22)
                        begin
                            tk.token_kind = cbor_pkg::TK_FALSE + 4'(inf - 5'd20);
                            have = 1'b1;
                            fin = 1'b1;
                        end
                        else if (mj != 3'd7 && inf < 5'd24)
                        begin
                            arg = {59'd0, inf};
                            have = 1'b1;
                        end
                        else
                        begin
                            case (inf)
                                5'd24:   left_next = 4'd1;
                                5'd25:   left_next = 4'd2;
                                5'd26:   left_next = 4'd4;
                                default: left_next = 4'd8;
                            endcase
                            acc_next = '0;
                            phase_next = cbor_pkg::PH_ARG;
                        end
                    end
                end
                default:
                begin
                    have = 1'b0;
                end
            endcase

            // finish_head when the argument became known
            if (have && st == cbor_pkg::ST_OK &&
                (phase_reg == cbor_pkg::PH_ARG ||
                 (phase_reg == cbor_pkg::PH_HEAD && !(mj == 3'd7))))
            begin
                case (major_next)
                    3'd0:
                    begin
                        if (arg > cbor_pkg::INT64_TOP)
                        begin
                            st = cbor_pkg::ST_UINT_BIG;
                        end
                        else
                        begin
                            tk.token_kind = cbor_pkg::TK_UINT;
                            tk.token_value = arg;
                            fin = 1'b1;
                        end
                    end
                    3'd1:
                    begin
                        if (arg >= cbor_pkg::INT64_TOP)
                        begin
                            st = cbor_pkg::ST_NEG_BIG;
                        end
                        else
                        begin
                            tk.token_kind = cbor_pkg::TK_NEGINT;
                            tk.token_value = ~arg;
                            fin = 1'b1;
                        end
                    end
                    3'd2, 3'd3:
                    begin
                        tk.token_kind = {1'b0, major_next};
                        tk.token_value = arg;
                        tk.is_map_key = (major_next == 3'd3) && inkey;
                        if (arg != 64'd0)
                        begin
                            pay_next = arg;
                            phase_next = cbor_pkg::PH_PAYLOAD;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    3'd4, 3'd5:
                    begin
                        tk.token_kind = {1'b0, major_next};
                        tk.token_value = arg;
                        if (arg != 64'd0)
                        begin
                            if (lvl_reg >= LW'(MAX_DEPTH))
                            begin
                                st = cbor_pkg::ST_TOO_DEEP;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                wr_addr = AW'(lvl_reg);
                                wr_data = {arg, major_next == 3'd5, major_next == 3'd5};
                                lvl_next = lvl_reg + LW'(1);
                                phase_next = cbor_pkg::PH_HEAD;
                            end
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    default:
                    begin
                        tk.token_kind = cbor_pkg::TK_FLOAT;
                        if (info_reg == 5'd25)
                        begin
                            tk.token_value = {32'd0, cbor_pkg::widen_half(arg[15:0])};
                            tk.float_format = cbor_pkg::FF_HALF;
                        end
                        else if (info_reg == 5'd26)
                        begin
                            tk.token_value = {32'd0, arg[31:0]};
                            tk.float_format = cbor_pkg::FF_SGL;
                        end
                        else
                        begin
                            tk.token_value = arg;
                            tk.float_format = cbor_pkg::FF_DBL;
                        end
                        fin = 1'b1;
                    end
                endcase
            end
            else if (phase_reg == cbor_pkg::PH_ARG && have && major_reg == 3'd7)
            begin
                tk.token_kind = cbor_pkg::TK_FLOAT;
                if (info_reg == 5'd25)
                begin
                    tk.token_value = {32'd0, cbor_pkg::widen_half(arg[15:0])};
                    tk.float_format = cbor_pkg::FF_HALF;
                end
                else if (info_reg == 5'd26)
                begin
                    tk.token_value = {32'd0, arg[31:0]};
                    tk.float_format = cbor_pkg::FF_SGL;
                end
                else
                begin
                    tk.token_value = arg;
                    tk.float_format = cbor_pkg::FF_DBL;
                end
                fin = 1'b1;
            end
            if (st != cbor_pkg::ST_OK)
            begin
                fin = 1'b0;
                wr_en = 1'b0;
                lvl_next = lvl_reg;
            end
            // first finish_item iteration done here, using the read top entry
            if (fin)
            begin
                if (lvl_reg == '0)
                begin
                    phase_next = cbor_pkg::PH_DONE;
                end
                else if (t_map && t_key)
                begin
                    wr_en = 1'b1;
                    wr_data = {t_rem, t_map, 1'b0};
                    phase_next = cbor_pkg::PH_HEAD;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_data = {nrem, t_map, t_map};
                    if (nrem != 64'd0)
                    begin
                        phase_next = cbor_pkg::PH_HEAD;
                    end
                    else
                    begin
                        lvl_next = lvl_m1;
                        have = 1'b0;
                        tk_next = tk;
                        phase_next = cbor_pkg::PH_POP;
                    end
                end
            end
        end

        // emit
        if (busy_reg && phase_next != cbor_pkg::PH_POP &&
            !(phase_reg == cbor_pkg::PH_POP && lvl_next != lvl_reg))
        begin
            if (st != cbor_pkg::ST_OK)
            begin
                tk = '0;
                tk.token_kind = cbor_pkg::TK_STATUS;
                have = 1'b1;
                phase_next = cbor_pkg::PH_DRAIN;
            end
            if (eom_reg)
            begin
                if (!have)
                begin
                    tk = '0;
                    tk.token_kind = cbor_pkg::TK_STATUS;
                end
                if (st == cbor_pkg::ST_OK && !wasdr_reg && phase_next != cbor_pkg::PH_DONE)
                begin
                    st = cbor_pkg::ST_TRUNC;
                end
                have = 1'b1;
                phase_next = cbor_pkg::PH_HEAD;
                acc_next = '0;
                left_next = '0;
                major_next = '0;
                info_next = '0;
                pay_next = '0;
                lvl_next = '0;
            end
            busy_next = 1'b0;
            if (have)
            begin
                ov_next = 1'b1;
                od_next = tk;
                od_next.message_done = eom_reg;
                od_next.status = st;
            end
        end
        else if (busy_reg && phase_reg == cbor_pkg::PH_POP)
        begin
            phase_next = cbor_pkg::PH_POP;
        end
    end

endmodule

>>> hw/rtl/cbor_stream_decoder_chk.sv
// Port-level checker for the CBOR stream decoder, bound to the top level.
// Depends on cbor_pkg.
module cbor_stream_decoder_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input cbor_pkg::in_req_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input cbor_pkg::out_req_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_no_take_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while result pending");

    a_status_only_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != cbor_pkg::ST_OK |->
        out_data.token_value == 64'd0 || out_data.token_kind != cbor_pkg::TK_STATUS)
        else $error("error result carries a value");

    a_eom_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.end_of_message |=> !in_ready)
        else $error("end mark gave no result cycle");

endmodule

bind cbor_stream_decoder_top cbor_stream_decoder_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
